// ===== sv/dub_pkg.sv =====
// ----------------------------------------------------------------------------
// dub_pkg: shared types and constants of the discounted UCB arm selector
// Command and status groups between controller and datapath, iterative unit
// operation codes and the fixed-point constants.
// ----------------------------------------------------------------------------
package dub_pkg;

    localparam int unsigned STAT_W    = 32;      // Q16.16 count and reward
    localparam int unsigned DIV_N     = 48;      // dividend width of the divider
    localparam int unsigned WORD_W    = 64;      // unit operand and result width
    localparam int unsigned CNT_W     = 6;       // unit iteration counter
    localparam int unsigned DIV_ITER  = 48;
    localparam int unsigned SQRT_ITER = 32;
    localparam int unsigned SCORE_W   = 50;
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [15:0] LN2_Q16   = 16'd45426;

    typedef enum logic {
        OP_DIV  = 1'b0,
        OP_SQRT = 1'b1
    } t_unit_op;

    typedef enum logic [1:0] {
        SRC_MEAN  = 2'd0,
        SRC_RATIO = 2'd1,
        SRC_ROOT  = 2'd2
    } t_unit_src;

    typedef struct packed {
        logic      load_in;
        logic      idx_clr;
        logic      idx_inc;
        logic      mem_rd;
        logic      decay_mul;
        logic      mem_wr;
        logic      step_inc;
        logic      sum_clr;
        logic      sum_acc;
        logic      norm_shift;
        logic      sq_init;
        logic      sq_step;
        logic      ln_mul;
        logic      conf_mul;
        logic      best_clr;
        logic      arm_latch;
        logic      unit_start;
        t_unit_op  unit_op;
        t_unit_src unit_src;
        logic      mean_latch;
        logic      exp_mul;
        logic      score_cmp;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic first_phase;
        logic idx_last;
        logic cnt_zero;
        logic sum_small;
        logic norm_top;
        logic sq_last;
        logic unit_done;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/discounted_ucb_arm_selector.sv =====
// An append walks the arms after the request is taken: read, decay and write per arm.
// A select in the first N_ARMS steps loads its result as soon as the output is free.
// A scored select sums the counts, takes the logarithm, runs two divides and a square
// root on the shared divide/square-root unit per arm with a nonzero count, skips empty
// arms and loads the result. One request is in work at a time; a waiting result does
// not block appends. Reset is synchronous; arm statistics read as zero at once.
// ----------------------------------------------------------------------------
// discounted_ucb_arm_selector: discounted UCB bandit arm selector
// APB register file, sequencing controller and arm statistics datapath.
// ----------------------------------------------------------------------------
module discounted_ucb_arm_selector #(
    parameter int unsigned N_ARMS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [2:0]  i_played_arm,
    input  logic        i_reward,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_chosen_arm,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dub_pkg::*;

    localparam logic [1:0] REG_DISCOUNT   = 2'd0;
    localparam logic [1:0] REG_CONFIDENCE = 2'd1;
    localparam logic [1:0] REG_BOUND      = 2'd2;

    logic [16:0] r_discount;
    logic [15:0] r_confidence;
    logic [15:0] r_bound;
    logic        wr_en;
    t_cmd        cmd;
    t_sts        sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_discount   <= 17'd64881;
            r_confidence <= 16'd256;
            r_bound      <= 16'd256;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_DISCOUNT:   r_discount   <= pwdata[16:0];
                REG_CONFIDENCE: r_confidence <= pwdata[15:0];
                REG_BOUND:      r_bound      <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (paddr[3:2])
            REG_DISCOUNT:   prdata = 32'(r_discount);
            REG_CONFIDENCE: prdata = 32'(r_confidence);
            REG_BOUND:      prdata = 32'(r_bound);
            default:        prdata = '0;
        endcase
    end

    dub_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dub_datapath #(
        .N_ARMS (N_ARMS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_played_arm (i_played_arm),
        .i_reward     (i_reward),
        .i_discount   (r_discount),
        .i_confidence (r_confidence),
        .i_bound      (r_bound),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_chosen_arm (o_chosen_arm)
    );

`ifndef SYNTHESIS
    a_ready_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted but input stays ready");

    a_discount_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && wr_en && paddr[3:2] == REG_DISCOUNT |=> r_discount == $past(pwdata[16:0]))
        else $error("discount write lost");

    a_bound_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && wr_en && paddr[3:2] == REG_BOUND |=> r_bound == $past(pwdata[15:0]))
        else $error("bound write lost");
`endif

endmodule

// ===== sv/dub_iter.sv =====
// ----------------------------------------------------------------------------
// dub_iter: shared iterative divide and square-root unit
// Restoring division, one quotient bit per cycle, and bitwise integer square
// root, one result bit per cycle.
// ----------------------------------------------------------------------------
module dub_iter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  dub_pkg::t_unit_op            i_op,
    input  logic [dub_pkg::WORD_W-1:0]   i_a,
    input  logic [dub_pkg::STAT_W-1:0]   i_b,
    output logic                         o_done,
    output logic [dub_pkg::WORD_W-1:0]   o_res
);
    import dub_pkg::*;

    logic                r_busy;
    logic                r_done;
    t_unit_op            r_op;
    logic [CNT_W-1:0]    r_cnt;
    logic [WORD_W-1:0]   r_x;
    logic [WORD_W-1:0]   r_y;
    logic [WORD_W-1:0]   r_b;
    logic [STAT_W-1:0]   r_r;
    logic [STAT_W-1:0]   r_d;

    logic [STAT_W:0]     rem_sh;
    logic                rem_ge;
    logic [WORD_W-1:0]   trial;
    logic                root_ge;

    // one division or square-root step
    always_comb begin
        rem_sh  = {r_r, r_x[DIV_N-1]};
        rem_ge  = rem_sh >= {1'b0, r_d};
        trial   = r_y + r_b;
        root_ge = r_x >= trial;
    end

    // sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // operands and partial results
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op  <= i_op;
            r_x   <= i_a;
            r_y   <= '0;
            r_r   <= '0;
            r_d   <= i_b;
            r_b   <= WORD_W'(1) << (WORD_W - 2);
            r_cnt <= (i_op == OP_DIV) ? CNT_W'(DIV_ITER - 1) : CNT_W'(SQRT_ITER - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_op == OP_DIV) begin
                r_x <= r_x << 1;
                r_y <= {r_y[WORD_W-2:0], rem_ge};
                r_r <= rem_ge ? STAT_W'(rem_sh - {1'b0, r_d}) : rem_sh[STAT_W-1:0];
            end else begin
                if (root_ge) begin
                    r_x <= r_x - trial;
                    r_y <= (r_y >> 1) + r_b;
                end else begin
                    r_y <= r_y >> 1;
                end
                r_b <= r_b >> 2;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_y;

endmodule

// ===== sv/dub_datapath.sv =====
// ----------------------------------------------------------------------------
// dub_datapath: arm statistics, logarithm, scoring and result register
// Holds the per-arm count and reward memories, the step counter, the log
// pipeline registers and the best-arm tracking; runs on controller commands.
// ----------------------------------------------------------------------------
module dub_datapath #(
    parameter int unsigned N_ARMS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dub_pkg::t_cmd i_cmd,
    output dub_pkg::t_sts o_sts,
    input  logic [2:0]    i_played_arm,
    input  logic          i_reward,
    input  logic [16:0]   i_discount,
    input  logic [15:0]   i_confidence,
    input  logic [15:0]   i_bound,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [2:0]    o_chosen_arm
);
    import dub_pkg::*;

    localparam int unsigned IDX_W   = $clog2(N_ARMS);
    localparam int unsigned CMP_W   = (IDX_W > 3) ? IDX_W : 3;
    localparam int unsigned SUM_W   = STAT_W + IDX_W;
    localparam int unsigned SHIFT_W = $clog2(SUM_W);
    localparam int unsigned LOG_W   = SHIFT_W + 16;
    localparam int unsigned CP_W    = 16 + LOG_W;
    localparam int unsigned CL_W    = 16 + LOG_W + 8;

    // arm statistics
    logic [STAT_W-1:0] mem_cnt [N_ARMS];
    logic [STAT_W-1:0] mem_rew [N_ARMS];
    logic [N_ARMS-1:0] r_vld;
    logic [STAT_W-1:0] r_rd_cnt;
    logic [STAT_W-1:0] r_rd_rew;
    logic              r_rd_vld;

    logic [IDX_W-1:0]  r_idx;
    logic [7:0]        r_step;
    logic [2:0]        r_arm;
    logic              r_rew_in;
    logic [STAT_W-1:0] r_pc;
    logic [STAT_W-1:0] r_pr;

    logic [SUM_W-1:0]  r_norm;
    logic [SHIFT_W-1:0] r_shift;
    logic [30:0]       r_m;
    logic [15:0]       r_frac;
    logic [3:0]        r_sqc;
    logic [LOG_W-1:0]  r_lnv;
    logic [CL_W-1:0]   r_cl;

    logic [STAT_W-1:0] r_n;
    logic [STAT_W-1:0] r_rw;
    logic [DIV_N-1:0]  r_mean;
    logic [SCORE_W-1:0] r_exp;
    logic [SCORE_W-1:0] r_best;
    logic [IDX_W-1:0]  r_best_arm;

    logic              r_ov;
    logic [2:0]        r_oarm;

    logic [STAT_W-1:0] cnt_val;
    logic [STAT_W-1:0] rew_val;
    logic [16:0]       disc;
    logic [48:0]       prod_c;
    logic [48:0]       prod_r;
    logic              hit;
    logic [STAT_W:0]   add_c;
    logic [STAT_W:0]   add_r;
    logic [STAT_W-1:0] sat_c;
    logic [STAT_W-1:0] sat_r;
    logic [61:0]       sq;
    logic [31:0]       sq_top;
    logic [SHIFT_W-1:0] int_part;
    logic [LOG_W-1:0]  log2v;
    logic [LOG_W+15:0] ln_prod;
    logic [CP_W-1:0]   conf_prod;
    logic [WORD_W-1:0] unit_a;
    logic              unit_done;
    logic [WORD_W-1:0] unit_res;
    logic [49:0]       exp_prod;
    logic [SCORE_W-1:0] score;
    logic              first_phase;
    logic [7:0]        step_m1;

    // decode read data and build the append values
    always_comb begin
        cnt_val  = r_rd_vld ? r_rd_cnt : '0;
        rew_val  = r_rd_vld ? r_rd_rew : '0;
        disc     = (i_discount > ONE_Q16) ? ONE_Q16 : i_discount;
        prod_c   = cnt_val * disc;
        prod_r   = rew_val * disc;
        hit      = CMP_W'(r_idx) == CMP_W'(r_arm);
        add_c    = {1'b0, r_pc} + ((hit) ? (STAT_W + 1)'(ONE_Q16) : '0);
        add_r    = {1'b0, r_pr} + ((hit && r_rew_in) ? (STAT_W + 1)'(ONE_Q16) : '0);
        sat_c    = add_c[STAT_W] ? '1 : add_c[STAT_W-1:0];
        sat_r    = add_r[STAT_W] ? '1 : add_r[STAT_W-1:0];
        sq       = r_m * r_m;
        sq_top   = sq[61:30];
        int_part = SHIFT_W'(SUM_W - 1 - 16) - r_shift;
        log2v    = {int_part, r_frac};
        ln_prod  = log2v * LN2_Q16;
        conf_prod = i_confidence * r_lnv;
        exp_prod = {i_bound, 1'b0} * unit_res[31:0];
        score    = SCORE_W'(r_mean) + r_exp;
        step_m1  = r_step - 8'd1;
        first_phase = step_m1 < 8'(N_ARMS);
    end

    // select the unit operand
    always_comb begin
        case (i_cmd.unit_src)
            SRC_MEAN:  unit_a = WORD_W'({r_rw, 16'b0});
            SRC_RATIO: unit_a = WORD_W'(r_cl);
            SRC_ROOT:  unit_a = {unit_res[DIV_N-1:0], 16'b0};
            default:   unit_a = '0;
        endcase
    end

    dub_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.unit_start),
        .i_op    (i_cmd.unit_op),
        .i_a     (unit_a),
        .i_b     (r_n),
        .o_done  (unit_done),
        .o_res   (unit_res)
    );

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            mem_cnt[r_idx] <= sat_c;
            mem_rew[r_idx] <= sat_r;
        end
        if (i_cmd.mem_rd) begin
            r_rd_cnt <= mem_cnt[r_idx];
            r_rd_rew <= mem_rew[r_idx];
        end
    end

    // valid bits, step counter, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_step   <= 8'd1;
            r_ov     <= 1'b0;
        end else begin
            if (i_cmd.mem_wr) begin
                r_vld[r_idx] <= 1'b1;
            end
            if (i_cmd.mem_rd) begin
                r_rd_vld <= r_vld[r_idx];
            end
            if (i_cmd.step_inc && r_step != 8'd255) begin
                r_step <= r_step + 8'd1;
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_arm    <= i_played_arm;
            r_rew_in <= i_reward;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.decay_mul) begin
            r_pc <= prod_c[47:16];
            r_pr <= prod_r[47:16];
        end
        if (i_cmd.sum_clr) begin
            r_norm  <= '0;
            r_shift <= '0;
        end else if (i_cmd.sum_acc) begin
            r_norm <= r_norm + SUM_W'(cnt_val);
        end else if (i_cmd.norm_shift) begin
            r_norm  <= r_norm << 1;
            r_shift <= r_shift + SHIFT_W'(1);
        end
        if (i_cmd.sq_init) begin
            r_m    <= r_norm[SUM_W-1 -: 31];
            r_frac <= '0;
            r_sqc  <= '0;
        end else if (i_cmd.sq_step) begin
            r_m    <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
            r_frac <= {r_frac[14:0], sq_top[31]};
            r_sqc  <= r_sqc + 4'd1;
        end
        if (i_cmd.ln_mul) begin
            r_lnv <= o_sts.sum_small ? '0 : ln_prod[LOG_W+15:16];
        end
        if (i_cmd.conf_mul) begin
            r_cl <= {conf_prod, 8'b0};
        end
        if (i_cmd.arm_latch) begin
            r_n  <= cnt_val;
            r_rw <= rew_val;
        end
        if (i_cmd.mean_latch) begin
            r_mean <= unit_res[DIV_N-1:0];
        end
        if (i_cmd.exp_mul) begin
            r_exp <= SCORE_W'(exp_prod[49:8]);
        end
        if (i_cmd.best_clr) begin
            r_best     <= '0;
            r_best_arm <= '0;
        end else if (i_cmd.score_cmp && score > r_best) begin
            r_best     <= score;
            r_best_arm <= r_idx;
        end
        if (i_cmd.out_load) begin
            r_oarm <= first_phase ? step_m1[2:0] : 3'(r_best_arm);
        end
    end

    // report status
    always_comb begin
        o_sts.first_phase = first_phase;
        o_sts.idx_last    = r_idx == IDX_W'(N_ARMS - 1);
        o_sts.cnt_zero    = cnt_val == '0;
        o_sts.sum_small   = r_norm < SUM_W'(ONE_Q16);
        o_sts.norm_top    = r_norm[SUM_W-1];
        o_sts.sq_last     = r_sqc == 4'd15;
        o_sts.unit_done   = unit_done;
        o_sts.out_free    = !r_ov || i_out_ready;
    end

    assign o_out_valid  = r_ov;
    assign o_chosen_arm = r_oarm;

endmodule

// ===== sv/dub_ctrl.sv =====
// ----------------------------------------------------------------------------
// dub_ctrl: sequencing state machine of the arm selector
// Walks the arms for decay on append, and outside the first phase for count sum,
// logarithm and scoring on select; issues one command group per cycle.
// ----------------------------------------------------------------------------
module dub_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_mode,
    output logic          o_in_ready,
    input  dub_pkg::t_sts i_sts,
    output dub_pkg::t_cmd o_cmd
);
    import dub_pkg::*;

    typedef enum logic [20:0] {
        ST_IDLE      = 21'b000000000000000000001,
        ST_A_RD      = 21'b000000000000000000010,
        ST_A_MUL     = 21'b000000000000000000100,
        ST_A_WR      = 21'b000000000000000001000,
        ST_S_RD      = 21'b000000000000000010000,
        ST_S_ACC     = 21'b000000000000000100000,
        ST_L_NORM    = 21'b000000000000001000000,
        ST_L_SQ      = 21'b000000000000010000000,
        ST_L_MUL     = 21'b000000000000100000000,
        ST_L_CONF    = 21'b000000000001000000000,
        ST_P_RD      = 21'b000000000010000000000,
        ST_P_CHK     = 21'b000000000100000000000,
        ST_P_MEAN_GO = 21'b000000001000000000000,
        ST_P_MEAN_W  = 21'b000000010000000000000,
        ST_P_RAT_GO  = 21'b000000100000000000000,
        ST_P_RAT_W   = 21'b000001000000000000000,
        ST_P_ROOT_GO = 21'b000010000000000000000,
        ST_P_ROOT_W  = 21'b000100000000000000000,
        ST_P_EXP     = 21'b001000000000000000000,
        ST_P_CMP     = 21'b010000000000000000000,
        ST_OUT       = 21'b100000000000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    o_cmd.sum_clr = 1'b1;
                    if (i_mode) begin
                        n_state = ST_A_RD;
                    end else if (i_sts.first_phase) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_S_RD;
                    end
                end
            end
            ST_A_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state = ST_A_MUL;
            end
            ST_A_MUL: begin
                o_cmd.decay_mul = 1'b1;
                n_state = ST_A_WR;
            end
            ST_A_WR: begin
                o_cmd.mem_wr = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.step_inc = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = ST_A_RD;
                end
            end
            ST_S_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state = ST_S_ACC;
            end
            ST_S_ACC: begin
                o_cmd.sum_acc = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = ST_L_NORM;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = ST_S_RD;
                end
            end
            ST_L_NORM: begin
                if (i_sts.sum_small) begin
                    n_state = ST_L_MUL;
                end else if (i_sts.norm_top) begin
                    o_cmd.sq_init = 1'b1;
                    n_state = ST_L_SQ;
                end else begin
                    o_cmd.norm_shift = 1'b1;
                end
            end
            ST_L_SQ: begin
                o_cmd.sq_step = 1'b1;
                if (i_sts.sq_last) begin
                    n_state = ST_L_MUL;
                end
            end
            ST_L_MUL: begin
                o_cmd.ln_mul = 1'b1;
                n_state = ST_L_CONF;
            end
            ST_L_CONF: begin
                o_cmd.conf_mul = 1'b1;
                o_cmd.best_clr = 1'b1;
                o_cmd.idx_clr  = 1'b1;
                n_state = ST_P_RD;
            end
            ST_P_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state = ST_P_CHK;
            end
            ST_P_CHK: begin
                o_cmd.arm_latch = 1'b1;
                if (!i_sts.cnt_zero) begin
                    n_state = ST_P_MEAN_GO;
                end else if (i_sts.idx_last) begin
                    n_state = ST_OUT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = ST_P_RD;
                end
            end
            ST_P_MEAN_GO: begin
                o_cmd.unit_start = 1'b1;
                o_cmd.unit_op    = OP_DIV;
                o_cmd.unit_src   = SRC_MEAN;
                n_state = ST_P_MEAN_W;
            end
            ST_P_MEAN_W: begin
                if (i_sts.unit_done) begin
                    o_cmd.mean_latch = 1'b1;
                    n_state = ST_P_RAT_GO;
                end
            end
            ST_P_RAT_GO: begin
                o_cmd.unit_start = 1'b1;
                o_cmd.unit_op    = OP_DIV;
                o_cmd.unit_src   = SRC_RATIO;
                n_state = ST_P_RAT_W;
            end
            ST_P_RAT_W: begin
                if (i_sts.unit_done) begin
                    n_state = ST_P_ROOT_GO;
                end
            end
            ST_P_ROOT_GO: begin
                o_cmd.unit_start = 1'b1;
                o_cmd.unit_op    = OP_SQRT;
                o_cmd.unit_src   = SRC_ROOT;
                n_state = ST_P_ROOT_W;
            end
            ST_P_ROOT_W: begin
                if (i_sts.unit_done) begin
                    n_state = ST_P_EXP;
                end
            end
            ST_P_EXP: begin
                o_cmd.exp_mul = 1'b1;
                n_state = ST_P_CMP;
            end
            ST_P_CMP: begin
                o_cmd.score_cmp = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = ST_OUT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = ST_P_RD;
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
